// ----- hw/rtl/shash24_pkg.sv -----
// Shared constants and the queue entry type for the 24-bit string hasher.
package shash24_pkg;

    localparam logic [31:0] HASH_SEED       = 32'h9E37_79B9;
    localparam logic [23:0] HASH_ZERO_SUBST = 24'h80_0000;
    localparam int          QUEUE_DEPTH     = 4;

    typedef enum logic [1:0] {
        OP_PAIR,
        OP_TAIL,
        OP_EMPTY
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic       last;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } op_t;

endpackage

// ----- hw/rtl/shash24_front.sv -----
// Front end: accepts bytes, pairs them and hands mixing work to the queue.
module shash24_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              empty_string,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic              queue_full,
    output logic              push,
    output shash24_pkg::op_t  push_op
);

    logic       held_flag_reg;
    logic       held_flag_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic       accept;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;

    always_comb
    begin
        held_flag_next  = held_flag_reg;
        held_byte_next  = held_byte_reg;
        push            = 1'b0;
        push_op.kind    = shash24_pkg::OP_EMPTY;
        push_op.last    = 1'b1;
        push_op.byte_a  = held_byte_reg;
        push_op.byte_b  = data_byte;
        if (accept)
        begin
            if (empty_string)
            begin
                // drop any partial string
                push           = 1'b1;
                held_flag_next = 1'b0;
            end
            else if (held_flag_reg)
            begin
                push           = 1'b1;
                push_op.kind   = shash24_pkg::OP_PAIR;
                push_op.last   = last_byte;
                held_flag_next = 1'b0;
            end
            else if (last_byte)
            begin
                push           = 1'b1;
                push_op.kind   = shash24_pkg::OP_TAIL;
                push_op.byte_a = data_byte;
            end
            else
            begin
                held_flag_next = 1'b1;
                held_byte_next = data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_flag_reg <= 1'b0;
        end
        else
        begin
            held_flag_reg <= held_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

endmodule

// ----- hw/rtl/shash24_queue.sv -----
// Short queue of mixing operations between the front and back ends.
module shash24_queue #(
    parameter int DEPTH = shash24_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  shash24_pkg::op_t  push_op,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output shash24_pkg::op_t  pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    shash24_pkg::op_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full   = count_reg == CNT_W'(DEPTH);
    assign valid  = count_reg != '0;
    assign pop_op = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

endmodule

// ----- hw/rtl/shash24_back.sv -----
// Back end: mixes the running hash, runs the avalanche and holds the result.
module shash24_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_valid,
    input  shash24_pkg::op_t  queue_op,
    output logic              pop,
    output logic [23:0]       hash_value,
    output logic              hash_valid,
    input  logic              hash_stall
);

    logic                    advance;
    logic [31:0]             h_reg;
    logic [31:0]             h_next;

    logic                    m1_valid_reg;
    logic                    m1_last_reg;
    shash24_pkg::op_kind_t   m1_kind_reg;
    logic [31:0]             m1_val_reg;
    logic [31:0]             m1_val_next;
    logic [31:0]             m1_sum;
    logic [31:0]             mix_out;

    logic                    m2_valid_reg;
    logic [31:0]             m2_val_reg;
    logic                    f1_valid_reg;
    logic [31:0]             f1_val_reg;
    logic [31:0]             f1_x;
    logic [31:0]             f1_next;
    logic                    f2_valid_reg;
    logic [31:0]             f2_val_reg;
    logic [31:0]             f2_x;
    logic [31:0]             f2_next;
    logic [31:0]             out_x;
    logic [23:0]             out_next;

    logic                    out_valid_reg;
    logic [23:0]             out_val_reg;

    // whole pipeline holds while a finished hash waits at the output
    assign advance = !(out_valid_reg && hash_stall);
    // a pair that is not last must land in h_reg before the next operation reads it
    assign pop     = advance && queue_valid && !(m1_valid_reg && !m1_last_reg);

    assign m1_sum = h_reg + {24'd0, queue_op.byte_a};

    always_comb
    begin
        case (queue_op.kind)
            shash24_pkg::OP_PAIR:
                m1_val_next = (m1_sum << 16) ^ (({24'd0, queue_op.byte_b} << 11) ^ m1_sum);
            shash24_pkg::OP_TAIL:
                m1_val_next = m1_sum ^ (m1_sum << 11);
            default:
                m1_val_next = shash24_pkg::HASH_SEED;
        endcase
    end

    always_comb
    begin
        case (m1_kind_reg)
            shash24_pkg::OP_PAIR: mix_out = m1_val_reg + (m1_val_reg >> 11);
            shash24_pkg::OP_TAIL: mix_out = m1_val_reg + (m1_val_reg >> 17);
            default:              mix_out = m1_val_reg;
        endcase
    end

    always_comb
    begin
        h_next = h_reg;
        if (pop && queue_op.last)
        begin
            h_next = shash24_pkg::HASH_SEED;
        end
        else if (m1_valid_reg && !m1_last_reg)
        begin
            h_next = mix_out;
        end
    end

    assign f1_x     = m2_val_reg ^ (m2_val_reg << 3);
    assign f1_next  = f1_x + (f1_x >> 5);
    assign f2_x     = f1_val_reg ^ (f1_val_reg << 2);
    assign f2_next  = f2_x + (f2_x >> 15);
    assign out_x    = f2_val_reg ^ (f2_val_reg << 10);
    assign out_next = (out_x[23:0] == 24'd0) ? shash24_pkg::HASH_ZERO_SUBST : out_x[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= shash24_pkg::HASH_SEED;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            h_reg         <= h_next;
            m1_valid_reg  <= pop;
            m2_valid_reg  <= m1_valid_reg && m1_last_reg;
            f1_valid_reg  <= m2_valid_reg;
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_last_reg <= queue_op.last;
            m1_kind_reg <= queue_op.kind;
            m1_val_reg  <= m1_val_next;
            m2_val_reg  <= mix_out;
            f1_val_reg  <= f1_next;
            f2_val_reg  <= f2_next;
            out_val_reg <= out_next;
        end
    end

    assign hash_valid = out_valid_reg;
    assign hash_value = out_val_reg;

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid |-> hash_value != 24'd0)
        else $error("zero hash emitted");

    a_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (m1_valid_reg && !m1_last_reg) |-> !pop)
        else $error("operation issued before running hash updated");

    a_h_update: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && m1_valid_reg && !m1_last_reg) |=> h_reg == $past(mix_out))
        else $error("running hash not written back");

endmodule

// ----- hw/rtl/string_hash_24bit_top.sv -----
// Top level of the 24-bit string hasher: front end, operation queue and back end.
// Takes one byte item per clock while the queue has room; the front pairs bytes and
// queues a mixing operation for each pair, odd trailing byte or empty string, and the
// back end applies it to the running hash. A pair that does not end the string blocks
// the back end from popping while its result is written back, which never limits
// throughput as such a pair spans two items. The hash of a string passes through the
// queue entry, two mixing stages, two avalanche stages and the output register, and
// is held in the output register until taken; while it waits the whole back end holds.
module string_hash_24bit_top #(
    parameter int QUEUE_DEPTH = shash24_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty_string,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic [23:0] hash_value,
    output logic        hash_valid,
    input  logic        hash_stall
);

    logic             push;
    shash24_pkg::op_t push_op;
    logic             queue_full;
    logic             pop;
    logic             queue_valid;
    shash24_pkg::op_t queue_op;

    shash24_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty_string (empty_string),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .queue_full   (queue_full),
        .push         (push),
        .push_op      (push_op)
    );

    shash24_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .valid   (queue_valid),
        .pop_op  (queue_op)
    );

    shash24_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_valid (queue_valid),
        .queue_op    (queue_op),
        .pop         (pop),
        .hash_value  (hash_value),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall)
    );

endmodule

// ----- test/shash24_checker.sv -----
// Checker for the 24-bit string hasher: watches both channels, predicts each hash, compares.
module shash24_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty_string,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [23:0] hash_value,
    input  logic        hash_valid,
    input  logic        hash_stall,
    output int          fail_count,
    output int          outstanding
);

    logic [31:0] hash_acc     = shash24_pkg::HASH_SEED;
    logic [7:0]  held         = 8'h00;
    logic        have_held    = 1'b0;
    logic [23:0] expected_hashes[$];

    function automatic logic [31:0] mix_byte_pair(input logic [31:0] h, input logic [7:0] a,
                                                  input logic [7:0] b);
        logic [31:0] x;
        x = h + {24'd0, a};
        x = (x << 16) ^ (({24'd0, b} << 11) ^ x);
        x = x + (x >> 11);
        return x;
    endfunction

    function automatic logic [31:0] mix_odd_tail(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] x;
        x = h + {24'd0, c};
        x = x ^ (x << 11);
        x = x + (x >> 17);
        return x;
    endfunction

    function automatic logic [23:0] avalanche24(input logic [31:0] h);
        logic [31:0] x;
        logic [23:0] r;
        x = h;
        x = x ^ (x << 3);
        x = x + (x >> 5);
        x = x ^ (x << 2);
        x = x + (x >> 15);
        x = x ^ (x << 10);
        r = x[23:0];
        if (r == 24'd0)
            r = shash24_pkg::HASH_ZERO_SUBST;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] mixed;
        logic [23:0] want;
        if (!rst_n)
        begin
            hash_acc   = shash24_pkg::HASH_SEED;
            held       = 8'h00;
            have_held  = 1'b0;
            fail_count = 0;
            expected_hashes.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results trail their items through the pipeline, so check the output first.
            if (hash_valid && !hash_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $error("hash_value: expected none, actual 0x%06h", hash_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        $error("hash_value: expected 0x%06h, actual 0x%06h", want, hash_value);
                        fail_count++;
                    end
                end
            end

            if (byte_valid && !byte_stall)
            begin
                if (empty_string)
                begin
                    // Drop any partial string and emit the hash of nothing.
                    expected_hashes.push_back(avalanche24(shash24_pkg::HASH_SEED));
                    hash_acc  = shash24_pkg::HASH_SEED;
                    held      = 8'h00;
                    have_held = 1'b0;
                end
                else if (have_held)
                begin
                    mixed     = mix_byte_pair(hash_acc, held, data_byte);
                    held      = 8'h00;
                    have_held = 1'b0;
                    if (last_byte)
                    begin
                        expected_hashes.push_back(avalanche24(mixed));
                        hash_acc = shash24_pkg::HASH_SEED;
                    end
                    else
                        hash_acc = mixed;
                end
                else if (last_byte)
                begin
                    expected_hashes.push_back(avalanche24(mix_odd_tail(hash_acc, data_byte)));
                    hash_acc = shash24_pkg::HASH_SEED;
                end
                else
                begin
                    held      = data_byte;
                    have_held = 1'b1;
                end
            end

            outstanding <= expected_hashes.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the 24-bit string hasher: clock, reset, stimulus and verdict.
module tb_top;

    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic        last_byte    = 1'b0;
    logic        empty_string = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        hash_stall   = 1'b0;
    wire         byte_stall;
    wire  [23:0] hash_value;
    wire         hash_valid;

    int fail_count;
    int outstanding;
    bit hold_req    = 1'b0;
    int items_sent  = 0;
    int burst_left  = 1;
    int cycle_count = 0;

    string_hash_24bit_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty_string (empty_string),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .hash_value   (hash_value),
        .hash_valid   (hash_valid),
        .hash_stall   (hash_stall)
    );

    shash24_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty_string (empty_string),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .hash_value   (hash_value),
        .hash_valid   (hash_valid),
        .hash_stall   (hash_stall),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, hold it until taken, then close the burst if it is spent.
    task automatic send_item(input logic [7:0] b, input logic l, input logic e);
        int gap;
        data_byte    <= b;
        last_byte    <= l;
        empty_string <= e;
        byte_valid   <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  pick;
        int  len;
        bit  broken;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty strings, with last both low and high
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // Single-byte strings take the tail mix
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // Two-byte strings end on a pair
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // Odd final byte after a pair
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // Even final byte after a pair
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h02, 1'b0, 1'b0);
        send_item(8'h03, 1'b0, 1'b0);
        send_item(8'hFE, 1'b1, 1'b0);
        // Empty while a byte is held
        send_item(8'h12, 1'b0, 1'b0);
        send_item(8'h34, 1'b0, 1'b1);
        // Empty after a pair has altered the running hash
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h02, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b0);
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_item(8'($urandom), 1'($urandom), 1'b1);
            else
            begin
                len    = (pick < 12) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                broken = ($urandom_range(0, 19) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if (broken && i == len - 1)
                        send_item(8'($urandom), 1'($urandom), 1'b1);
                    else
                        send_item(8'($urandom), (i == len - 1), 1'b0);
                end
            end

            if (!hold_done && items_sent >= 150)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 280)
            begin
                drain_results();
                drain_done = 1'b1;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("string_hash_24bit_top verification clean");
        else
            $display("string_hash_24bit_top verification failed");
        $finish;
    end

    // Receiver: stall on a shifting rate, with one long hold-off on request.
    initial
    begin
        int stall_pct;
        int phase_left;
        stall_pct  = 0;
        phase_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hash_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 15;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                hash_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("string_hash_24bit_top verification failed");
        $finish;
    end

endmodule
